// ===== sv/bmpdec_pkg.sv =====
// bmpdec_pkg: types and constants shared by the 24-bit BMP stream decoder.
// No dependencies; every bmpdec module imports it.
`timescale 1ns / 1ps

package bmpdec_pkg;

  localparam int unsigned CFG_W  = 17;  // max_dimension register width
  localparam int unsigned SIZE_W = 17;  // width / height result fields

  localparam logic [CFG_W-1:0] MAXDIM_RESET = 17'd100000;

  // Header layout
  localparam logic [5:0]  HDR_LAST   = 6'd53;
  localparam logic [5:0]  OFF_MAGIC0 = 6'd0;
  localparam logic [5:0]  OFF_MAGIC1 = 6'd1;
  localparam logic [5:0]  OFF_WIDTH  = 6'd18;
  localparam logic [5:0]  OFF_HEIGHT = 6'd22;
  localparam logic [5:0]  OFF_BPP    = 6'd28;
  localparam logic [7:0]  MAGIC_B    = 8'h42;
  localparam logic [7:0]  MAGIC_M    = 8'h4D;
  localparam logic [15:0] BPP_24     = 16'd24;

  // Byte position inside a BGR triple
  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_RED   = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_WAIT   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_HDR_GOOD = 2'd1,
    KIND_HDR_BAD  = 2'd2,
    KIND_TRUNC    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              row_last;
    logic              image_last;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } out_item_t;

  // Input stage contents handed to the decode core
  typedef struct packed {
    logic     vld;
    in_item_t item;
  } stage_t;

  // Decode core result handed to the output register
  typedef struct packed {
    logic      have;
    out_item_t item;
  } result_t;

endpackage

// ===== sv/bmpdec_in_reg.sv =====
// bmpdec_in_reg: input register stage of the BMP decoder.
// Depends on bmpdec_pkg (in_item_t, stage_t).
`timescale 1ns / 1ps

module bmpdec_in_reg
  import bmpdec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     advance,
  output stage_t   stage
);

  logic     vld_r, vld_nxt;
  in_item_t item_r, item_nxt;
  logic     accept;

  // Stall only while a held byte cannot move on
  assign in_stall = vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (accept) begin
      vld_nxt  = 1'b1;
      item_nxt = in_data;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !advance |=> vld_r && $stable(item_r))
    else $error("input stage lost or changed a blocked byte");

endmodule

// ===== sv/bmpdec_core.sv =====
// bmpdec_core: header parser, pixel assembler and file state machine.
// Depends on bmpdec_pkg (phase_t, kind_t, stage_t, result_t, constants).
`timescale 1ns / 1ps

module bmpdec_core
  import bmpdec_pkg::*;
#(
  parameter int unsigned DIM_BITS = 17
)(
  input  logic             clk,
  input  logic             rst_n,
  input  stage_t           stage,
  input  logic             advance,
  input  logic [CFG_W-1:0] max_dim,
  output result_t          result
);

  localparam logic [31:0] DIM_MAX = (32'd1 << DIM_BITS) - 32'd1;

  phase_t              phase_r, phase_nxt;
  logic [5:0]          hdr_off_r, hdr_off_nxt;
  logic                magic_r, magic_nxt;
  logic [31:0]         raw_w_r, raw_w_nxt;
  logic [31:0]         raw_h_r, raw_h_nxt;
  logic [15:0]         depth_r, depth_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [1:0]          bip_r, bip_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [7:0]          blue_r, blue_nxt;
  logic [7:0]          green_r, green_nxt;

  logic [7:0]          byte_in;
  logic                last_in;
  logic [1:0]          lane;
  logic                w_ok, h_ok, hdr_good;
  logic [DIM_BITS-1:0] width_d, height_d, col_inc, row_inc;
  logic                done;

  assign byte_in  = stage.item.data_byte;
  assign last_in  = stage.item.stream_end;
  assign width_d  = raw_w_r[DIM_BITS-1:0];
  assign height_d = raw_h_r[DIM_BITS-1:0];
  assign col_inc  = col_r + {{(DIM_BITS-1){1'b0}}, 1'b1};
  assign row_inc  = row_r + {{(DIM_BITS-1){1'b0}}, 1'b1};

  // Sizes are signed 32-bit on file: reject negative, zero and oversize
  assign w_ok = !raw_w_r[31] && (raw_w_r != 32'd0) &&
                (raw_w_r <= {15'd0, max_dim}) && (raw_w_r <= DIM_MAX);
  assign h_ok = !raw_h_r[31] && (raw_h_r != 32'd0) &&
                (raw_h_r <= {15'd0, max_dim}) && (raw_h_r <= DIM_MAX);
  assign hdr_good = magic_r && w_ok && h_ok && (depth_r == BPP_24);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_off_nxt = hdr_off_r;
    magic_nxt   = magic_r;
    raw_w_nxt   = raw_w_r;
    raw_h_nxt   = raw_h_r;
    depth_nxt   = depth_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    bip_nxt     = bip_r;
    pad_nxt     = pad_r;
    blue_nxt    = blue_r;
    green_nxt   = green_r;
    lane        = 2'(hdr_off_r);
    done        = 1'b0;
    result      = '0;

    case (phase_r)
      PH_HEADER: begin
        if (hdr_off_r == OFF_MAGIC0) begin
          magic_nxt = (byte_in == MAGIC_B);
        end else if (hdr_off_r == OFF_MAGIC1) begin
          magic_nxt = magic_r && (byte_in == MAGIC_M);
        end else if (hdr_off_r >= OFF_WIDTH && hdr_off_r < OFF_WIDTH + 6'd4) begin
          lane = 2'(hdr_off_r - OFF_WIDTH);
          raw_w_nxt[{lane, 3'b000} +: 8] = byte_in;
        end else if (hdr_off_r >= OFF_HEIGHT && hdr_off_r < OFF_HEIGHT + 6'd4) begin
          lane = 2'(hdr_off_r - OFF_HEIGHT);
          raw_h_nxt[{lane, 3'b000} +: 8] = byte_in;
        end else if (hdr_off_r >= OFF_BPP && hdr_off_r < OFF_BPP + 6'd2) begin
          lane = 2'(hdr_off_r - OFF_BPP);
          depth_nxt[{lane[0], 3'b000} +: 8] = byte_in;
        end
        hdr_off_nxt = hdr_off_r + 6'd1;

        if (hdr_off_r >= HDR_LAST) begin
          result.have = 1'b1;
          if (!hdr_good) begin
            result.item.kind = KIND_HDR_BAD;
            phase_nxt        = last_in ? PH_HEADER : PH_WAIT;
            hdr_off_nxt      = '0;
          end else if (last_in) begin
            result.item.kind = KIND_TRUNC;
            hdr_off_nxt      = '0;
          end else begin
            result.item.kind   = KIND_HDR_GOOD;
            result.item.width  = raw_w_r[SIZE_W-1:0];
            result.item.height = raw_h_r[SIZE_W-1:0];
            phase_nxt   = PH_PIXELS;
            hdr_off_nxt = '0;
            col_nxt     = '0;
            row_nxt     = '0;
            bip_nxt     = BYTE_BLUE;
            pad_nxt     = 2'd0;
          end
        end else if (last_in) begin
          result.have      = 1'b1;
          result.item.kind = KIND_HDR_BAD;
          hdr_off_nxt      = '0;
        end
      end

      PH_PIXELS: begin
        if (pad_r != 2'd0) begin
          // Skip row padding
          pad_nxt = pad_r - 2'd1;
          done    = (pad_r == 2'd1) && (row_r >= height_d);
        end else if (bip_r == BYTE_BLUE) begin
          blue_nxt = byte_in;
          bip_nxt  = BYTE_GREEN;
        end else if (bip_r == BYTE_GREEN) begin
          green_nxt = byte_in;
          bip_nxt   = BYTE_RED;
        end else begin
          bip_nxt           = BYTE_BLUE;
          result.have       = 1'b1;
          result.item.kind  = KIND_PIXEL;
          result.item.red   = byte_in;
          result.item.green = green_r;
          result.item.blue  = blue_r;
          col_nxt           = col_inc;
          if (col_inc >= width_d) begin
            col_nxt              = '0;
            row_nxt              = row_inc;
            pad_nxt              = raw_w_r[1:0];
            result.item.row_last = 1'b1;
            if (row_inc >= height_d) begin
              result.item.image_last = 1'b1;
              done = (raw_w_r[1:0] == 2'd0);
            end
          end
        end

        if (done) begin
          phase_nxt = last_in ? PH_HEADER : PH_WAIT;
        end else if (last_in) begin
          // Data still due: report truncation instead of anything else
          result           = '0;
          result.have      = 1'b1;
          result.item.kind = KIND_TRUNC;
          phase_nxt        = PH_HEADER;
        end
      end

      default: begin
        if (last_in) begin
          phase_nxt   = PH_HEADER;
          hdr_off_nxt = '0;
        end
      end
    endcase

    if (!stage.vld) begin
      result.have = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_off_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      bip_r     <= BYTE_BLUE;
      pad_r     <= 2'd0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      hdr_off_r <= hdr_off_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      bip_r     <= bip_nxt;
      pad_r     <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      magic_r <= magic_nxt;
      raw_w_r <= raw_w_nxt;
      raw_h_r <= raw_h_nxt;
      depth_r <= depth_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage.item.stream_end |=> phase_r == PH_HEADER && hdr_off_r == 6'd0)
    else $error("end of file did not restart the header parser");

  a_pixel_on_red: assert property (@(posedge clk) disable iff (!rst_n)
    result.have && result.item.kind == KIND_PIXEL |->
      phase_r == PH_PIXELS && bip_r == BYTE_RED && pad_r == 2'd0)
    else $error("pixel emitted outside the red byte");

  a_hdr_status_pos: assert property (@(posedge clk) disable iff (!rst_n)
    result.have && result.item.kind == KIND_HDR_GOOD |->
      phase_r == PH_HEADER && hdr_off_r == HDR_LAST && !stage.item.stream_end)
    else $error("header good emitted at the wrong offset");

endmodule

// ===== sv/bmpdec_out_reg.sv =====
// bmpdec_out_reg: result register of the BMP decoder.
// Depends on bmpdec_pkg (result_t, out_item_t).
`timescale 1ns / 1ps

module bmpdec_out_reg
  import bmpdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  result_t   result,
  input  logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      vld_r, vld_nxt;
  out_item_t data_r, data_nxt;
  logic      load;

  assign load = advance && result.have;

  always_comb begin
    vld_nxt  = vld_r && out_stall;
    data_nxt = data_r;
    if (load) begin
      vld_nxt  = 1'b1;
      data_nxt = result.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !vld_r || !out_stall)
    else $error("pending result overwritten");

endmodule

// ===== sv/bmp24_stream_decoder.sv =====
// bmp24_stream_decoder: top level of the 24-bit uncompressed BMP decoder.
// Depends on bmpdec_pkg, bmpdec_in_reg, bmpdec_core and bmpdec_out_reg.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------
//   in_     | in  | in_valid/in_stall  | in_item_t: data_byte, stream_end
//   out_    | out | out_valid/out_stall| out_item_t: kind, rgb, marks, sizes
//   cfg_    | in  | cfg_valid/cfg_ready| max_dimension, 17 bits
//
// One byte per cycle sustained while out_stall is low; a byte is held in the
// input register, and its result (if any) is loaded into the result register
// when that byte advances, which raises out_valid.
// The rate is set by the single decode step between the two registers.
// Reset (synchronous, rst_n low) returns to header parsing with
// max_dimension at 100000. A stalled result holds the output register; at
// most one more byte is taken into the input register, then in_stall rises.
`timescale 1ns / 1ps

module bmp24_stream_decoder
  import bmpdec_pkg::*;
#(
  parameter int unsigned DIM_BITS = 17
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] max_dim_r, max_dim_nxt;
  stage_t           stage;
  result_t          result;
  logic             advance;

  // Configuration write: always ready, one transaction per cycle
  assign cfg_ready   = 1'b1;
  assign max_dim_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_dim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r <= MAXDIM_RESET;
    end else begin
      max_dim_r <= max_dim_nxt;
    end
  end

  // Advance the held byte whenever the result register can take a result
  assign advance = stage.vld && (!out_valid || !out_stall);

  bmpdec_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  bmpdec_core #(
    .DIM_BITS (DIM_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .max_dim (max_dim_r),
    .result  (result)
  );

  bmpdec_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for the 24-bit BMP stream decoder.
// Depends on bmpdec_pkg and bmp24_stream_decoder; a tracking class predicts
// every status and pixel result, and tasks feed whole files byte by byte.
`timescale 1ns / 1ps

module tb_top;
  import bmpdec_pkg::*;

  localparam int unsigned DIM_BITS = 17;
  localparam int unsigned GAP_PCT  = 27;
  localparam int unsigned PHASE_BYTES = 60;

  // Follow the decoder file by file: header parse, pixel assembly, padding
  // skip, and the wait for the end-of-file byte. Hold the results that are
  // still due from the block, oldest first.
  class bmp_frame_tracker;
    logic [CFG_W-1:0] max_dim;
    phase_t           phase;
    logic [5:0]       hdr_off;
    bit               magic_ok;
    logic [31:0]      raw_w;
    logic [31:0]      raw_h;
    logic [15:0]      depth;
    int unsigned      col;
    int unsigned      row;
    logic [1:0]       lane;
    logic [1:0]       pad_left;
    logic [7:0]       held_b;
    logic [7:0]       held_g;
    out_item_t        due_results[$];
    int               mismatches;

    function new();
      max_dim    = MAXDIM_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_HEADER;
      hdr_off  = '0;
      magic_ok = 1'b0;
      raw_w    = '0;
      raw_h    = '0;
      depth    = '0;
      col      = 0;
      row      = 0;
      lane     = BYTE_BLUE;
      pad_left = '0;
      held_b   = '0;
      held_g   = '0;
    endfunction

    function bit size_ok(logic [31:0] v);
      return !v[31] && v != 0 && v <= max_dim && v <= 32'((1 << DIM_BITS) - 1);
    endfunction

    // Advance the decoder state by one accepted byte and queue its result.
    function void absorb_byte(in_item_t it);
      out_item_t   r;
      bit          have;
      bit          done;
      bit          good;
      logic [7:0]  b;
      logic [5:0]  off;
      r    = '0;
      have = 1'b0;
      done = 1'b0;
      b    = it.data_byte;
      case (phase)
        PH_HEADER: begin
          off = hdr_off;
          if (off == OFF_MAGIC0) begin
            magic_ok = (b == MAGIC_B);
          end else if (off == OFF_MAGIC1) begin
            magic_ok = magic_ok && (b == MAGIC_M);
          end else if (off >= OFF_WIDTH && off < OFF_WIDTH + 4) begin
            raw_w |= 32'(b) << (8 * (off - OFF_WIDTH));
          end else if (off >= OFF_HEIGHT && off < OFF_HEIGHT + 4) begin
            raw_h |= 32'(b) << (8 * (off - OFF_HEIGHT));
          end else if (off >= OFF_BPP && off < OFF_BPP + 2) begin
            depth |= 16'(b) << (8 * (off - OFF_BPP));
          end
          hdr_off = off + 6'd1;
          if (off >= HDR_LAST) begin
            good = magic_ok && size_ok(raw_w) && size_ok(raw_h) && depth == BPP_24;
            have = 1'b1;
            if (!good) begin
              r.kind = KIND_HDR_BAD;
              if (it.stream_end) restart();
              else phase = PH_WAIT;
            end else if (it.stream_end) begin
              r.kind = KIND_TRUNC;
              restart();
            end else begin
              r.kind   = KIND_HDR_GOOD;
              r.width  = raw_w[SIZE_W-1:0];
              r.height = raw_h[SIZE_W-1:0];
              phase    = PH_PIXELS;
              col      = 0;
              row      = 0;
              lane     = BYTE_BLUE;
              pad_left = '0;
            end
          end else if (it.stream_end) begin
            have   = 1'b1;
            r.kind = KIND_HDR_BAD;
            restart();
          end
        end
        PH_PIXELS: begin
          if (pad_left != 0) begin
            pad_left--;
            if (pad_left == 0 && row >= raw_h) done = 1'b1;
          end else if (lane == BYTE_BLUE) begin
            held_b = b;
            lane   = BYTE_GREEN;
          end else if (lane == BYTE_GREEN) begin
            held_g = b;
            lane   = BYTE_RED;
          end else begin
            lane    = BYTE_BLUE;
            have    = 1'b1;
            r.kind  = KIND_PIXEL;
            r.red   = b;
            r.green = held_g;
            r.blue  = held_b;
            col++;
            if (col >= raw_w) begin
              col        = 0;
              row++;
              pad_left   = raw_w[1:0];
              r.row_last = 1'b1;
              if (row >= raw_h) begin
                r.image_last = 1'b1;
                if (pad_left == 0) done = 1'b1;
              end
            end
          end
          if (done) begin
            if (it.stream_end) restart();
            else phase = PH_WAIT;
          end else if (it.stream_end) begin
            // a short file overrides whatever this byte would have produced
            r      = '0;
            r.kind = KIND_TRUNC;
            have   = 1'b1;
            restart();
          end
        end
        default: begin
          if (it.stream_end) restart();
        end
      endcase
      if (have) due_results.push_back(r);
    endfunction

    // Compare one accepted result with the oldest one still due.
    function void match_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d rgb=%02h%02h%02h w=%0d h=%0d",
                   got.kind, got.red, got.green, got.blue, got.width, got.height);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.row_last !== want.row_last ||
          got.image_last !== want.image_last || got.width !== want.width ||
          got.height !== want.height) begin
        if (mismatches < 10) begin
          $display("mismatch: expected kind=%0d rgb=%02h%02h%02h rl=%0d il=%0d w=%0d h=%0d",
                   want.kind, want.red, want.green, want.blue, want.row_last,
                   want.image_last, want.width, want.height);
          $display("          actual   kind=%0d rgb=%02h%02h%02h rl=%0d il=%0d w=%0d h=%0d",
                   got.kind, got.red, got.green, got.blue, got.row_last,
                   got.image_last, got.width, got.height);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  bmp_frame_tracker tracker;
  logic [7:0]       file_q[$];
  int unsigned      bytes_sent = 0;
  bit               gaps_on    = 1'b1;
  bit               stall_on   = 1'b1;

  bmp24_stream_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Result side: stall at random while enabled, change only on the falling edge.
  always @(negedge clk) begin
    out_stall <= stall_on && ($urandom_range(99) < GAP_PCT);
  end

  // Check every result transaction at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(out_data);
  end

  // Drive one byte transaction and hold it until the block takes it. Call
  // at a falling edge; return at the falling edge after acceptance with
  // in_valid still high, so back-to-back bytes never drop valid.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte  = b;
    it.stream_end = last;
    if (gaps_on) begin
      while ($urandom_range(99) < GAP_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.absorb_byte(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid, then wait out every due result plus the pipeline depth, so
  // a byte with no result cannot still be in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] lim);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    tracker.max_dim = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one file: the 54-byte header, `rows` full rows of width w with
  // their padding, then `trail` loose bytes. Send it with stream_end on the
  // last byte sent; cut > 0 keeps that many bytes, cut < 0 drops -cut bytes.
  task automatic ship(input logic [31:0] w, input logic [31:0] h,
                      input int unsigned rows, input int unsigned trail,
                      input int cut, input logic [7:0] m0 = MAGIC_B,
                      input logic [7:0] m1 = MAGIC_M,
                      input logic [15:0] bpp = BPP_24);
    logic [7:0] v;
    int         n;
    for (int i = 0; i <= HDR_LAST; i++) begin
      v = 8'($urandom_range(255));
      if (i == OFF_MAGIC0) v = m0;
      else if (i == OFF_MAGIC1) v = m1;
      else if (i >= OFF_WIDTH && i < OFF_WIDTH + 4) v = w[8 * (i - OFF_WIDTH) +: 8];
      else if (i >= OFF_HEIGHT && i < OFF_HEIGHT + 4) v = h[8 * (i - OFF_HEIGHT) +: 8];
      else if (i >= OFF_BPP && i < OFF_BPP + 2) v = bpp[8 * (i - OFF_BPP) +: 8];
      file_q.push_back(v);
    end
    for (int r = 0; r < rows; r++) begin
      for (int j = 0; j < 3 * w + w[1:0]; j++) file_q.push_back(8'($urandom_range(255)));
    end
    repeat (trail) file_q.push_back(8'($urandom_range(255)));
    n = file_q.size();
    if (cut > 0 && cut < n) n = cut;
    else if (cut < 0) n = (n + cut < 1) ? 1 : n + cut;
    for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
    file_q.delete();
  endtask

  // Mostly clean small images; the rest short files, big headers cut off
  // early, damaged headers and plain noise.
  task automatic random_file();
    int unsigned pick;
    int unsigned lim;
    int unsigned n;
    logic [31:0] w;
    logic [31:0] h;
    pick = $urandom_range(99);
    lim  = (tracker.max_dim == 0) ? 1 : tracker.max_dim;
    w    = $urandom_range(1, 5);
    h    = $urandom_range(1, 3);
    if (pick < 60) begin
      ship(w, h, h, $urandom_range(0, 3), 0);
    end else if (pick < 70) begin
      ship(w, h, h, 0, $urandom_range(1, 54 + h * (3 * w + w[1:0]) - 1));
    end else if (pick < 78) begin
      ship($urandom_range(1, lim), $urandom_range(1, lim), 0, $urandom_range(0, 12), 0);
    end else if (pick < 90) begin
      case ($urandom_range(5))
        0: ship(w, h, h, 0, 0, 8'($urandom_range(255)));
        1: ship(w, h, h, 0, 0, MAGIC_B, 8'($urandom_range(255)));
        2: ship(w, h, h, 0, 0, MAGIC_B, MAGIC_M, 16'($urandom_range(65535)));
        3: begin
          if ($urandom_range(1)) w = 0;
          else h = 0;
          ship(w, h, 0, $urandom_range(0, 4), 0);
        end
        4: begin
          if ($urandom_range(1)) w = 32'h8000_0000 | $urandom;
          else h = 32'h8000_0000 | $urandom;
          ship(w, h, 0, $urandom_range(0, 4), 0);
        end
        default: begin
          w = $urandom_range(1) ? lim + $urandom_range(1, 5000) : $urandom;
          ship(w, h, 0, $urandom_range(0, 4), 0);
        end
      endcase
    end else begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(255)), i == n - 1 || $urandom_range(9) == 0);
    end
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] lim, input bit calm);
    int unsigned start;
    write_limit(lim);
    gaps_on  = !calm;
    stall_on = !calm;
    start    = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) random_file();
  endtask

  initial begin
    tracker = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed files at the reset limit.
    ship(1, 1, 1, 0, 0);                           // final row padding closes image
    ship(4, 2, 2, 3, 0);                           // no padding, trailing bytes
    ship(3, 2, 2, 0, -3);                          // end on last pixel, padding due
    ship(2, 1, 1, 0, 0, 8'h58);                    // bad first magic byte
    ship(2, 1, 1, 0, 0, MAGIC_B, 8'h4E);           // bad second magic byte
    ship(2, 1, 1, 0, 0, MAGIC_B, MAGIC_M, 16'd32); // wrong depth
    ship(0, 1, 0, 2, 0);                           // zero width
    ship(1, 32'hFFFF_FFFE, 0, 2, 0);               // top-down image
    ship(32'd100001, 1, 0, 4, 0);                  // over the limit
    ship(32'd131072, 1, 0, 2, 0);                  // beyond the size counters
    ship(2, 2, 2, 0, 10);                          // end inside header
    ship(2, 2, 2, 0, 54);                          // end on last header byte
    ship(2, 2, 2, 0, 1);                           // one-byte file
    ship(2, 2, 2, 0, -5);                          // end on the red byte of a pixel, rows still due
    ship(32'd100000, 1, 0, 6, 0);                  // at the limit, end completes pixel

    // Limit extremes.
    write_limit('0);
    ship(1, 1, 1, 0, 0);
    write_limit(17'd1);
    ship(1, 1, 1, 0, 0);
    ship(2, 1, 1, 0, 0);
    write_limit(17'd131071);
    ship(32'd131071, 32'd131071, 0, 7, 0);

    // Random traffic under several limits; the third phase runs without idling.
    random_phase(17'd131071, 1'b0);
    random_phase(17'($urandom_range(1, 131071)), 1'b0);
    random_phase(17'($urandom_range(2, 6)), 1'b1);
    random_phase(MAXDIM_RESET, 1'b0);

    wait_drained();
    repeat (4) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("tb_top: errors");
    $finish;
  end

endmodule
